// ===== rtl/mh2s_pkg.sv =====
// Package for the streaming MurmurHash2 engine: mixing constant, byte masks,
// controller states and the command struct between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mh2s_pkg;

	localparam logic [31:0] MIX_M = 32'h5bd1e995;
	localparam int unsigned MIX_R = 24;
	localparam int unsigned FIN_R1 = 13;
	localparam int unsigned FIN_R2 = 15;
	localparam logic [2:0] FULL_COUNT = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_K1,
		ST_MUL_K2,
		ST_MUL_H,
		ST_FOLD,
		ST_MUL_T,
		ST_LOAD_T,
		ST_MUL_F,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		MUL_K,
		MUL_KMIX,
		MUL_H,
		MUL_HT,
		MUL_HFIN
	} mul_sel_t;

	typedef enum logic [1:0] {
		H_FOLD,
		H_PROD,
		H_FINAL
	} h_sel_t;

	typedef struct packed {
		logic     accept;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     h_en;
		h_sel_t   h_sel;
		logic     k_en;
		logic     out_load;
	} dp_cmd_t;

	function automatic logic [31:0] byte_mask(input logic [2:0] count);
		logic [31:0] mask;
		case (count)
			3'd0: mask = 32'h0000_0000;
			3'd1: mask = 32'h0000_00ff;
			3'd2: mask = 32'h0000_ffff;
			3'd3: mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
		return mask;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/murmurhash2_32_stream_top.sv =====
// Streaming 32-bit MurmurHash2 engine, top level.
// Connects mh2s_ctrl and mh2s_datapath; depends on mh2s_pkg.
//
// Usage: a message enters as a run of input transfers on in_valid/in_stall,
// each carrying up to four bytes in data_word (first byte in bits 7:0) and
// byte_count. The first transfer sets first_item and total_length, which
// seeds the accumulator; the final transfer sets last_item.
// One shared 32x32 multiplier is reused for every product, so input stalls
// while a full word goes through premix and fold or a partial word through
// its tail steps; an empty word that is not last causes no stall. A last
// item adds the final mix, after which the hash is loaded into the output
// register and shown on out_valid/hash_value.
// The result sits in an output register; new input transfers are taken
// while it waits. If the receiver stalls and a second result is ready, the
// engine holds in its final step and stalls input until the register frees.
// Reset clears the accumulator to zero and drops out_valid. The accumulator
// keeps the finished hash; a next item without first_item continues from it.
`timescale 1ns / 1ps
`default_nettype none

module murmurhash2_32_stream_top import mh2s_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        first_item,
	input  wire logic        last_item,
	input  wire logic [31:0] total_length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      hash_value
);

	dp_cmd_t cmd;

	mh2s_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.byte_count (byte_count),
		.last_item  (last_item),
		.out_stall  (out_stall),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.cmd        (cmd)
	);

	mh2s_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.data_word    (data_word),
		.byte_count   (byte_count),
		.first_item   (first_item),
		.total_length (total_length),
		.hash_value   (hash_value)
	);

endmodule

`default_nettype wire

// ===== rtl/mh2s_datapath.sv =====
// Datapath of the MurmurHash2 engine: accumulator, word and product registers
// around one shared 32-bit multiplier, plus the result register.
// Depends on mh2s_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mh2s_datapath import mh2s_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        first_item,
	input  wire logic [31:0] total_length,
	output logic [31:0]      hash_value
);

	logic [31:0] h_q;
	logic [31:0] k_q;
	logic [31:0] p_q;
	logic [31:0] hash_q;
	logic [31:0] mul_a;
	logic [31:0] prod;

	always_comb begin
		case (cmd.mul_sel)
			MUL_K:    mul_a = k_q;
			MUL_KMIX: mul_a = p_q ^ (p_q >> MIX_R);
			MUL_H:    mul_a = h_q;
			MUL_HT:   mul_a = h_q ^ k_q;
			MUL_HFIN: mul_a = h_q ^ (h_q >> FIN_R1);
			default:  mul_a = k_q;
		endcase
	end

	assign prod = mul_a * MIX_M;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (cmd.accept) begin
			if (first_item) begin
				h_q <= total_length;
			end
		end else if (cmd.h_en) begin
			case (cmd.h_sel)
				H_FOLD:  h_q <= p_q ^ k_q;
				H_FINAL: h_q <= p_q ^ (p_q >> FIN_R2);
				default: h_q <= p_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			k_q <= data_word & byte_mask(byte_count);
		end else if (cmd.k_en) begin
			k_q <= p_q;
		end
		if (cmd.mul_en) begin
			p_q <= prod;
		end
		if (cmd.out_load) begin
			hash_q <= p_q ^ (p_q >> FIN_R2);
		end
	end

	assign hash_value = hash_q;

endmodule

`default_nettype wire

// ===== rtl/mh2s_ctrl.sv =====
// Controller of the MurmurHash2 engine: sequences the shared multiplier
// through premix, fold, tail and final mix, and owns the result valid flag.
// Depends on mh2s_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mh2s_ctrl import mh2s_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [2:0] byte_count,
	input  wire logic       last_item,
	input  wire logic       out_stall,
	output logic            in_stall,
	output logic            out_valid,
	output dp_cmd_t         cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   last_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (byte_count >= FULL_COUNT) begin
						state_nxt = ST_MUL_K1;
					end else if (byte_count != 3'd0) begin
						state_nxt = ST_MUL_T;
					end else if (last_item) begin
						state_nxt = ST_MUL_F;
					end
				end
			end
			ST_MUL_K1: state_nxt = ST_MUL_K2;
			ST_MUL_K2: state_nxt = ST_MUL_H;
			ST_MUL_H:  state_nxt = ST_FOLD;
			ST_FOLD:   state_nxt = last_q ? ST_MUL_F : ST_IDLE;
			ST_MUL_T:  state_nxt = ST_LOAD_T;
			ST_LOAD_T: state_nxt = last_q ? ST_MUL_F : ST_IDLE;
			ST_MUL_F:  state_nxt = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{accept: 1'b0, mul_en: 1'b0, mul_sel: MUL_K, h_en: 1'b0,
			h_sel: H_PROD, k_en: 1'b0, out_load: 1'b0};
		unique case (state_q)
			ST_IDLE: cmd.accept = accept;
			ST_MUL_K1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_K;
			end
			ST_MUL_K2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_KMIX;
			end
			ST_MUL_H: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_H;
				cmd.k_en    = 1'b1;
			end
			ST_FOLD: begin
				cmd.h_en  = 1'b1;
				cmd.h_sel = H_FOLD;
			end
			ST_MUL_T: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_HT;
			end
			ST_LOAD_T: begin
				cmd.h_en  = 1'b1;
				cmd.h_sel = H_PROD;
			end
			ST_MUL_F: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_HFIN;
			end
			ST_FIN: begin
				cmd.out_load = out_free;
				cmd.mul_sel  = MUL_HFIN;
				cmd.h_en     = 1'b1;
				cmd.h_sel    = H_FINAL;
			end
			default: cmd.accept = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				last_q <= last_item;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for murmurhash2_32_stream_top: directed and random messages
// go through the valid/stall input channel, and each hash is checked against an internal model.
// Depends on the RTL top level and its package only.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [31:0] MULT = 32'h5bd1e995;
	localparam int unsigned WORD_TARGET = 1750;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        first_item;
	logic        last_item;
	logic [31:0] total_length;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] hash_value;

	logic [31:0] hash_state;
	logic [31:0] hashes_due[$];
	int unsigned words_sent;
	int unsigned fail_count;
	bit          idle_on;

	murmurhash2_32_stream_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_word(data_word),
		.byte_count(byte_count),
		.first_item(first_item),
		.last_item(last_item),
		.total_length(total_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hash_value(hash_value)
	);

	function automatic logic [31:0] absorb(input logic [31:0] h, input logic [31:0] word,
			input logic [2:0] count);
		logic [31:0] k;
		logic [31:0] mask;
		if (count >= 3'd4) begin
			k = word * MULT;
			k = k ^ (k >> 24);
			k = k * MULT;
			h = (h * MULT) ^ k;
		end else if (count != 3'd0) begin
			mask = (32'h1 << (8 * count)) - 32'h1;
			h = (h ^ (word & mask)) * MULT;
		end
		return h;
	endfunction

	function automatic logic [31:0] avalanche(input logic [31:0] h);
		h = h ^ (h >> 13);
		h = h * MULT;
		h = h ^ (h >> 15);
		return h;
	endfunction

	function automatic int unsigned draw_wait();
		return idle_on ? $urandom_range(0, 9) : 0;
	endfunction

	task automatic send_word(input logic [31:0] word, input logic [2:0] count,
			input logic first, input logic last, input logic [31:0] length);
		int unsigned gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= word;
		byte_count <= count;
		first_item <= first;
		last_item <= last;
		total_length <= length;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		if (first) begin
			hash_state = length;
		end
		hash_state = absorb(hash_state, word, count);
		if (last) begin
			hash_state = avalanche(hash_state);
			hashes_due.push_back(hash_state);
		end
		words_sent++;
	endtask

	task automatic send_message(input int unsigned nbytes, input logic [31:0] length,
			input bit empty_end);
		int unsigned nitems;
		int unsigned tail;
		int unsigned i;
		logic [2:0]  count;
		tail = nbytes % 4;
		nitems = nbytes / 4 + ((tail != 0) ? 1 : 0) + ((empty_end || nbytes == 0) ? 1 : 0);
		for (i = 0; i < nitems; i++) begin
			if (i < nbytes / 4) begin
				count = 3'd4;
			end else if (i == nbytes / 4 && tail != 0) begin
				count = tail[2:0];
			end else begin
				count = 3'd0;
			end
			send_word($urandom, count, i == 0, i == nitems - 1, (i == 0) ? length : $urandom);
		end
	endtask

	task automatic test_missing_first_after_reset();
		send_word($urandom, 3'd4, 1'b0, 1'b1, $urandom);
	endtask

	task automatic test_field_extremes();
		send_word(32'hffff_ffff, 3'd4, 1'b1, 1'b0, 32'hffff_ffff);
		send_word(32'h0000_0000, 3'd4, 1'b0, 1'b0, 32'h0000_0000);
		send_word(32'hffff_ffff, 3'd3, 1'b0, 1'b1, 32'hffff_ffff);
		send_word(32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000);
	endtask

	task automatic test_byte_counts();
		int c;
		send_word($urandom, 3'd0, 1'b1, 1'b0, 32'd30);
		for (c = 1; c <= 7; c++) begin
			send_word($urandom, c[2:0], 1'b0, 1'b0, $urandom);
		end
		send_word($urandom, 3'd0, 1'b0, 1'b1, $urandom);
	endtask

	task automatic test_first_and_last();
		send_word($urandom, 3'd4, 1'b1, 1'b1, 32'd4);
		send_word($urandom, 3'd2, 1'b1, 1'b1, 32'd2);
		send_word($urandom, 3'd1, 1'b1, 1'b1, 32'd1);
	endtask

	task automatic test_continue_after_emit();
		send_word($urandom, 3'd3, 1'b0, 1'b1, $urandom);
		send_word($urandom, 3'd4, 1'b0, 1'b0, $urandom);
		send_word($urandom, 3'd0, 1'b0, 1'b1, $urandom);
	endtask

	task automatic test_random_traffic();
		int unsigned nbytes;
		logic [31:0] length;
		while (words_sent < WORD_TARGET) begin
			idle_on = ($urandom_range(0, 9) != 0);
			if ($urandom_range(0, 99) < 80) begin
				nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
					: $urandom_range(0, 32);
				length = ($urandom_range(0, 19) == 0) ? $urandom : nbytes;
				send_message(nbytes, length, $urandom_range(0, 9) == 0);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), $urandom);
				end
			end
		end
		idle_on = 1'b1;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (hashes_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("murmurhash2_32_stream_top verification failed");
		$finish;
	end

	initial begin : result_check
		bit          took;
		int unsigned stall_left;
		logic [31:0] want;
		out_stall = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			took = out_valid && !out_stall;
			if (took) begin
				if (hashes_due.size() == 0) begin
					$error("hash_value unexpected transfer: expected none, actual %h", hash_value);
					fail_count++;
				end else begin
					want = hashes_due.pop_front();
					if (hash_value !== want) begin
						$error("hash_value mismatch: expected %h, actual %h", want, hash_value);
						fail_count++;
					end
				end
			end
			@(posedge clk);
			if (took) begin
				stall_left = draw_wait();
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_word = '0;
		byte_count = '0;
		first_item = 1'b0;
		last_item = 1'b0;
		total_length = '0;
		hash_state = '0;
		words_sent = 0;
		fail_count = 0;
		idle_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_missing_first_after_reset();
		test_field_extremes();
		test_byte_counts();
		test_first_and_last();
		test_continue_after_emit();
		test_random_traffic();
		drain_results();
		if (fail_count == 0) begin
			$display("murmurhash2_32_stream_top verification clean");
		end else begin
			$display("murmurhash2_32_stream_top verification failed");
		end
		$finish;
	end

endmodule
